[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the receiver port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/sca_pkg.sv]
// ----------------------------------------------------------------------------
// Smart card ATR/PPS receiver package
// Shared types, codes and constant tables of the receiver.
// ----------------------------------------------------------------------------
package sca_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_ARM   = 2'd2,
    CMD_IDLE  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic REG_EXPECTED_PPS0   = 1'b0;
  localparam logic REG_DEFAULT_DIVISOR = 1'b1;

  // Configuration reset values.
  localparam logic [7:0] RESET_PPS0    = 8'h10;
  localparam logic [3:0] RESET_DIVISOR = 4'd2;

  // Phase codes as reported with each result.
  localparam logic [2:0] PHASE_IDLE   = 3'd0;
  localparam logic [2:0] PHASE_ATR    = 3'd1;
  localparam logic [2:0] PHASE_HEADER = 3'd2;
  localparam logic [2:0] PHASE_DATA   = 3'd3;
  localparam logic [2:0] PHASE_DONE   = 3'd4;

  // Protocol bytes.
  localparam logic [7:0] PPS_START = 8'hFF;
  localparam logic [7:0] PPS_ZERO  = 8'h00;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_ATR    = 2'd1,
    JOB_REJECT = 2'd2,
    JOB_ECHO   = 2'd3
  } job_kind_e;

  // One queued job: everything the back needs to emit its results.
  typedef struct packed {
    job_kind_e       kind;
    logic [3:0][7:0] bytes;
    logic [3:0]      divisor;
    logic [2:0]      phase;
    logic            timer;
  } job_t;

  // Rate table lookup result.
  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } rate_hit_t;

  localparam int AnswerMax = 33;

  // Answer-to-reset bytes; positions past the fixed answer are zero.
  localparam logic [7:0] ANSWER_BYTES [AnswerMax] = '{
    8'h3b, 8'h97, 8'h96, 8'h80, 8'h1f, 8'hc6, 8'h45, 8'h41, 8'h4C, 8'h34, 8'h2B,
    8'h5F, 8'h54, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Supported PPS1/PCK pairs; the last entry is only reachable with 16 entries.
  localparam logic [15:0] RATE_PAIRS [16] = '{
    16'h31DE, 16'h11FE, 16'h12FD, 16'h13FC, 16'h14FB, 16'h15FA, 16'h16F9, 16'h18F7,
    16'h917E, 16'h927D, 16'h937C, 16'h947B, 16'h957A, 16'h9679, 16'h9778, 16'h0000
  };

  // Answer byte at a given position.
  function automatic logic [7:0] answer_byte(logic [5:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos < 6'(AnswerMax)) begin
      b = ANSWER_BYTES[pos];
    end
    return b;
  endfunction

  // First table entry below the entry limit that matches the pair.
  function automatic rate_hit_t rate_match(logic [15:0] pair, int unsigned entries);
    rate_hit_t r;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      if (i < int'(entries) && pair == RATE_PAIRS[i]) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

[src/sca_front.sv]
// ----------------------------------------------------------------------------
// Receiver front end
// Accepts items, tracks phase and byte count, and turns each item into a job.
// ----------------------------------------------------------------------------
module sca_front #(
  parameter int unsigned RATE_ENTRIES = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        data_length_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output sca_pkg::job_t     job_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_HEADER = 4'b0010,
    ST_DATA   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [7:0]          exp_q, exp_d;
  logic [3:0][7:0]     fb_q, fb_d;
  logic [7:0]          pps0_q;
  logic [3:0]          div_q;
  logic [3:0][7:0]     fb_new;
  logic [7:0]          cnt_inc;
  logic                pps_due;
  logic                accept;
  sca_pkg::rate_hit_t  rate;
  sca_pkg::job_t       job;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i;
  assign job_o       = job;

  // Classify the item and work out the next state and the job.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    fb_d    = fb_q;
    fb_new  = fb_q;
    if (cnt_q < 8'd4) begin
      fb_new[cnt_q[1:0]] = rx_byte_i;
    end
    cnt_inc = cnt_q + 8'd1;
    pps_due = (cnt_inc == 8'd4) || (cnt_inc == 8'd3 && fb_new[1] == sca_pkg::PPS_ZERO);
    rate    = sca_pkg::rate_match({fb_new[2], fb_new[3]}, RATE_ENTRIES);

    job         = '0;
    job.kind    = sca_pkg::JOB_STATUS;
    job.bytes   = fb_new;
    job.divisor = div_q;

    case (sca_pkg::cmd_e'(command_i))
      sca_pkg::CMD_RESET: begin
        job.kind = sca_pkg::JOB_ATR;
        state_d  = ST_IDLE;
      end
      sca_pkg::CMD_ARM: begin
        exp_d   = data_length_i;
        state_d = ST_DATA;
      end
      sca_pkg::CMD_IDLE: begin
        state_d = ST_IDLE;
        cnt_d   = 8'd0;
      end
      sca_pkg::CMD_BYTE: begin
        fb_d  = fb_new;
        cnt_d = cnt_inc;
        if (state_q == ST_IDLE) begin
          if (fb_new[0] == sca_pkg::PPS_START) begin
            if (pps_due) begin
              cnt_d = 8'd0;
              if (fb_new[1] != pps0_q) begin
                job.kind = sca_pkg::JOB_REJECT;
              end else if ((fb_new[0] ^ fb_new[1] ^ fb_new[2]) != fb_new[3]) begin
                // Bad check byte: only a status result goes out.
                job.kind = sca_pkg::JOB_STATUS;
              end else if (rate.hit) begin
                job.kind    = sca_pkg::JOB_ECHO;
                job.divisor = rate.idx + 4'd1;
              end else begin
                job.kind = sca_pkg::JOB_REJECT;
              end
            end
          end else if (cnt_inc == 8'd5) begin
            job.timer = 1'b1;
            state_d   = ST_HEADER;
          end
        end else if (state_q == ST_DATA && cnt_inc == exp_q) begin
          job.timer = 1'b1;
          state_d   = ST_DONE;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase

    // Phase code reported with a status result.
    case (state_d)
      ST_IDLE:   job.phase = sca_pkg::PHASE_IDLE;
      ST_HEADER: job.phase = sca_pkg::PHASE_HEADER;
      ST_DATA:   job.phase = sca_pkg::PHASE_DATA;
      ST_DONE:   job.phase = sca_pkg::PHASE_DONE;
      default:   job.phase = sca_pkg::PHASE_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 8'd0;
      exp_q   <= 8'd0;
      pps0_q  <= sca_pkg::RESET_PPS0;
      div_q   <= sca_pkg::RESET_DIVISOR;
    end else begin
      if (accept) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        exp_q   <= exp_d;
      end
      if (cfg_we_i && cfg_addr_i == sca_pkg::REG_EXPECTED_PPS0) begin
        pps0_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_addr_i == sca_pkg::REG_DEFAULT_DIVISOR) begin
        div_q <= cfg_wdata_i[3:0];
      end
    end
  end

  // Stored first bytes; their contents are undefined until written.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fb_q <= fb_d;
    end
  end

endmodule

[src/sca_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the front end from the result sequencer.
// ----------------------------------------------------------------------------
module sca_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sca_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output sca_pkg::job_t pop_data_o
);

  sca_pkg::job_t ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/sca_back.sv]
// ----------------------------------------------------------------------------
// Result sequencer
// Expands each queued job into its result items, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module sca_back #(
  parameter int unsigned ANSWER_LENGTH = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  sca_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          send_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic          set_divisor_o,
  output logic [3:0]    divisor_o,
  output logic [2:0]    phase_now_o,
  output logic          start_wait_timer_o
);

  localparam int unsigned MaxCount = (ANSWER_LENGTH > 4) ? ANSWER_LENGTH : 4;
  localparam int unsigned IdxW     = $clog2(MaxCount);
  localparam logic [IdxW-1:0] AtrLast = IdxW'(ANSWER_LENGTH - 1);

  logic [IdxW-1:0] idx_q;
  logic            ov_q;
  logic            load;
  logic            r_send, r_last, r_setdiv, r_timer;
  logic [7:0]      r_tx;
  logic [3:0]      r_div;
  logic [2:0]      r_phase;

  assign load        = job_valid_i && (!ov_q || out_ready_i);
  assign job_ready_o = load && r_last;

  // Result at the current position of the head job.
  always_comb begin
    r_send   = 1'b1;
    r_tx     = 8'h00;
    r_last   = 1'b0;
    r_setdiv = 1'b0;
    r_phase  = sca_pkg::PHASE_IDLE;
    r_timer  = 1'b0;
    case (job_i.kind)
      sca_pkg::JOB_STATUS: begin
        r_send  = 1'b0;
        r_last  = 1'b1;
        r_phase = job_i.phase;
        r_timer = job_i.timer;
      end
      sca_pkg::JOB_ATR: begin
        r_tx     = sca_pkg::answer_byte(6'(idx_q));
        r_last   = (idx_q == AtrLast);
        r_setdiv = (idx_q == '0);
        r_phase  = sca_pkg::PHASE_ATR;
      end
      sca_pkg::JOB_REJECT: begin
        r_tx     = (idx_q == IdxW'(1)) ? sca_pkg::PPS_ZERO : sca_pkg::PPS_START;
        r_last   = (idx_q == IdxW'(2));
        r_setdiv = r_last;
      end
      sca_pkg::JOB_ECHO: begin
        r_tx     = job_i.bytes[idx_q[1:0]];
        r_last   = (idx_q == IdxW'(3));
        r_setdiv = r_last;
      end
      default: begin
        r_send = 1'b0;
        r_last = 1'b1;
      end
    endcase
    r_div = r_setdiv ? job_i.divisor : 4'd0;
  end

  // Position counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= r_last ? '0 : idx_q + IdxW'(1);
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      send_valid_o       <= r_send;
      tx_byte_o          <= r_tx;
      last_o             <= r_last;
      set_divisor_o      <= r_setdiv;
      divisor_o          <= r_div;
      phase_now_o        <= r_phase;
      start_wait_timer_o <= r_timer;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[src/smart_card_atr_pps_receiver.sv]
// ----------------------------------------------------------------------------
// Smart card ATR/PPS receiver
// Card-side answer-to-reset and PPS baud negotiation front end.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one item per command:
//   reset request, received byte, arm data phase or return to idle. The output
//   channel (out_valid_o/out_ready_i) carries result items; last_o marks the
//   final result of an item. Configuration writes use cfg_we_i, cfg_addr_i and
//   cfg_wdata_i and take effect at once; write them only while the block idles.
//   When the sequencer is free, an accepted item passes through the job queue
//   and the output register before its first result is offered. The result
//   sequencer emits one result per cycle while out_ready_i is high, so an item
//   yields one result (status), three or four results (PPS reply) or
//   ANSWER_LENGTH results (answer-to-reset); that sequencer sets the sustained rate.
//   Items are taken back to back while the two-entry job queue has room.
//   When the receiver holds out_ready_i low, the output register holds its
//   result, the queue fills and in_ready_o drops.
//   Reset clears the phase, the byte count and the armed count, loads the
//   configuration defaults and empties the queue and output register.
// ----------------------------------------------------------------------------
module smart_card_atr_pps_receiver #(
  parameter int unsigned ANSWER_LENGTH = 14,
  parameter int unsigned RATE_ENTRIES  = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] data_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       send_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic       set_divisor_o,
  output logic [3:0] divisor_o,
  output logic [2:0] phase_now_o,
  output logic       start_wait_timer_o
);

  logic          fq_valid, fq_ready;
  sca_pkg::job_t fq_job;
  logic          qb_valid, qb_ready;
  sca_pkg::job_t qb_job;

  // Front end: classification and state.
  sca_front #(
    .RATE_ENTRIES(RATE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .data_length_i(data_length_i),
    .job_valid_o  (fq_valid),
    .job_ready_i  (fq_ready),
    .job_o        (fq_job)
  );

  // Job queue between the two halves.
  sca_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_job),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_job)
  );

  // Back end: result sequencing.
  sca_back #(
    .ANSWER_LENGTH(ANSWER_LENGTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (qb_valid),
    .job_ready_o       (qb_ready),
    .job_i             (qb_job),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .send_valid_o      (send_valid_o),
    .tx_byte_o         (tx_byte_o),
    .last_o            (last_o),
    .set_divisor_o     (set_divisor_o),
    .divisor_o         (divisor_o),
    .phase_now_o       (phase_now_o),
    .start_wait_timer_o(start_wait_timer_o)
  );

endmodule

[src/sca_checker.sv]
// ----------------------------------------------------------------------------
// Receiver port checker
// Checks output channel behavior of the receiver as seen on its ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sca_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       send_valid_i,
  input logic [7:0] tx_byte_i,
  input logic       last_i,
  input logic       set_divisor_i,
  input logic [3:0] divisor_i,
  input logic [2:0] phase_now_i,
  input logic       start_wait_timer_i
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A result that sends nothing is a single status result with empty fields.
  `ASSERT_IMPLY(a_status_shape, clk_i, rst_ni, out_valid_i && !send_valid_i,
                last_i && !set_divisor_i && tx_byte_i == 8'h00 && divisor_i == 4'd0)

  // The timer pulse only rides on a status result.
  `ASSERT_IMPLY(a_timer_status, clk_i, rst_ni, out_valid_i && start_wait_timer_i,
                !send_valid_i && last_i)

  // The divisor load of an answer-to-reset comes with its first byte.
  `ASSERT_IMPLY(a_atr_first, clk_i, rst_ni,
                out_valid_i && set_divisor_i && phase_now_i == sca_pkg::PHASE_ATR,
                send_valid_i && tx_byte_i == sca_pkg::ANSWER_BYTES[0] && !last_i)

endmodule

bind smart_card_atr_pps_receiver sca_checker u_sca_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .send_valid_i      (send_valid_o),
  .tx_byte_i         (tx_byte_o),
  .last_i            (last_o),
  .set_divisor_i     (set_divisor_o),
  .divisor_i         (divisor_o),
  .phase_now_i       (phase_now_o),
  .start_wait_timer_i(start_wait_timer_o)
);
